// ===== rtl/rle_record_decoder_defines.svh =====
// Assertion macros shared by the run-length decoder RTL.
`ifndef RLE_RECORD_DECODER_DEFINES_SVH
`define RLE_RECORD_DECODER_DEFINES_SVH

// Check cons in the same cycle whenever ante holds.
`define RLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante holds.
`define RLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rle_rd_pkg.sv =====
// Types and constants for the run-length record decoder.
`timescale 1ns / 1ps
package rle_rd_pkg;

    localparam int POSITION_BITS = 28;
    localparam int LEN_W         = 29;

    localparam logic [LEN_W-1:0] LEN_LIMIT   = LEN_W'(64'd1 << POSITION_BITS);
    localparam logic [31:0]      COUNT_MASK  = 32'h7fff_ffff;
    localparam logic [31:0]      REPEAT_FLAG = 32'h8000_0000;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_COUNT    = 3'd1,
        PH_LITERAL  = 3'd2,
        PH_FILLBYTE = 3'd3,
        PH_DONE     = 3'd4,
        PH_FAILED   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_FILL    = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_HEADER    = 3'd1,
        ERR_ZERO      = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_EARLY_END = 3'd4
    } t_error;

endpackage

// ===== rtl/rle_record_decoder.sv =====
// Streaming run-length record decoder: one encoded byte in, at most one result out.
`timescale 1ns / 1ps
`include "rle_record_decoder_defines.svh"

// rle_record_decoder takes one encoded byte per cycle while o_in_stall is low
// and shows its result, if any, in the cycle after; each byte's phase, count
// and position update is combinational. Results sit in an output register:
// a new byte is taken in the same cycle as the held result leaves, and
// o_in_stall is raised only when that register is full and the consumer
// stalls. Literal bytes come out as single-byte writes, a repeat
// record as one fill request (position, value, length). Writing the length
// register restarts the decoder; write it only while no request is pending.
// After finish or an error, further bytes are swallowed without a result.
module rle_record_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rle_rd_pkg::LEN_W-1:0]   i_cfg_expected_length,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_code_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_kind,
    output logic [rle_rd_pkg::POSITION_BITS-1:0] o_position,
    output logic [7:0]                     o_byte_value,
    output logic [rle_rd_pkg::LEN_W-1:0]   o_run_length,
    output logic                           o_finished,
    output logic [2:0]                     o_error_code
);
    import rle_rd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_byte_idx, n_byte_idx;
    logic [23:0]        r_word, n_word;
    logic [LEN_W-1:0]   r_wpos, n_wpos;
    logic [LEN_W-1:0]   r_left, n_left;
    logic [LEN_W-1:0]   r_exp;

    logic               r_out_valid;
    t_kind              r_kind;
    logic [POSITION_BITS-1:0] r_pos;
    logic [7:0]         r_val;
    logic [LEN_W-1:0]   r_run;
    logic               r_fin;
    t_error             r_err;

    logic               in_acc;
    logic               word_done;
    logic [31:0]        full_word;
    logic [31:0]        count;
    logic [LEN_W-1:0]   remaining;
    logic [LEN_W-1:0]   lit_pos;
    logic [LEN_W-1:0]   fill_pos;
    logic               active;
    t_error             err;
    t_kind              res_kind;
    logic [7:0]         res_val;
    logic [LEN_W-1:0]   res_run;
    logic               res_have;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_acc      = i_in_valid & ~o_in_stall;

    assign word_done = (r_byte_idx == 2'd3);
    assign full_word = {i_code_byte, r_word};
    assign count     = full_word & COUNT_MASK;
    assign remaining = r_exp - r_wpos;
    assign lit_pos   = r_wpos + LEN_W'(1);
    assign fill_pos  = r_wpos + r_left;
    assign active    = (r_phase == PH_HEADER) || (r_phase == PH_COUNT) ||
                       (r_phase == PH_LITERAL) || (r_phase == PH_FILLBYTE);

    // Next state of the decoder for the byte on the input.
    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_word     = r_word;
        n_wpos     = r_wpos;
        n_left     = r_left;
        err        = ERR_NONE;
        unique case (r_phase) inside
            PH_HEADER, PH_COUNT: begin
                n_byte_idx = r_byte_idx + 2'd1;
                unique case (r_byte_idx)
                    2'd0:    n_word[7:0]   = i_code_byte;
                    2'd1:    n_word[15:8]  = i_code_byte;
                    2'd2:    n_word[23:16] = i_code_byte;
                    default: n_word        = r_word;
                endcase
                if (word_done) begin
                    if (r_phase == PH_HEADER) begin
                        if (full_word != {3'b000, r_exp} || r_exp > LEN_LIMIT) begin
                            err = ERR_HEADER;
                        end else if (r_exp == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end else begin
                        if (count == '0) begin
                            err = ERR_ZERO;
                        end else if (count > {3'b000, remaining}) begin
                            err = ERR_TOO_LARGE;
                        end else begin
                            n_left  = count[LEN_W-1:0];
                            n_phase = ((full_word & REPEAT_FLAG) != '0) ? PH_FILLBYTE
                                                                         : PH_LITERAL;
                        end
                    end
                end
            end
            PH_LITERAL: begin
                n_wpos = lit_pos;
                n_left = r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    n_phase = (lit_pos >= r_exp) ? PH_DONE : PH_COUNT;
                end
            end
            PH_FILLBYTE: begin
                n_wpos  = fill_pos;
                n_left  = '0;
                n_phase = (fill_pos >= r_exp) ? PH_DONE : PH_COUNT;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (err != ERR_NONE) begin
            n_phase = PH_FAILED;
        end else if (active && i_last_byte && n_phase != PH_DONE) begin
            err     = ERR_EARLY_END;
            n_phase = PH_FAILED;
        end
    end

    // Result request for the byte on the input.
    always_comb begin
        res_kind = KIND_STATUS;
        res_val  = 8'd0;
        res_run  = '0;
        res_have = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                res_have = (n_phase == PH_DONE);
            end
            PH_LITERAL: begin
                res_kind = KIND_LITERAL;
                res_val  = i_code_byte;
                res_run  = LEN_W'(1);
                res_have = 1'b1;
            end
            PH_FILLBYTE: begin
                res_kind = KIND_FILL;
                res_val  = i_code_byte;
                res_run  = r_left;
                res_have = 1'b1;
            end
            default: begin
                res_have = 1'b0;
            end
        endcase
        if (err != ERR_NONE) begin
            res_have = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_byte_idx <= 2'd0;
            r_word     <= '0;
            r_wpos     <= '0;
            r_left     <= '0;
            r_exp      <= '0;
        end else if (i_cfg_valid) begin
            // register write restarts the decode
            r_exp      <= i_cfg_expected_length;
            r_phase    <= PH_HEADER;
            r_byte_idx <= 2'd0;
            r_word     <= '0;
            r_wpos     <= '0;
            r_left     <= '0;
        end else if (in_acc) begin
            r_phase    <= n_phase;
            r_byte_idx <= n_byte_idx;
            r_word     <= n_word;
            r_wpos     <= n_wpos;
            r_left     <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_have) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_have) begin
            r_kind <= res_kind;
            r_pos  <= r_wpos[POSITION_BITS-1:0];
            r_val  <= res_val;
            r_run  <= res_run;
            r_fin  <= (n_phase == PH_DONE);
            r_err  <= err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_position   = r_pos;
    assign o_byte_value = r_val;
    assign o_run_length = r_run;
    assign o_finished   = r_fin;
    assign o_error_code = r_err;

    `RLE_ASSERT_NOW(a_wpos_in_range, 1'b1, r_wpos <= r_exp,
        "write position passed expected length")
    `RLE_ASSERT_NOW(a_record_nonempty,
        r_phase == PH_LITERAL || r_phase == PH_FILLBYTE, r_left != '0,
        "data phase with empty record")
    `RLE_ASSERT_NEXT(a_error_fails, in_acc && err != ERR_NONE && !i_cfg_valid,
        r_phase == PH_FAILED && o_out_valid && o_error_code == $past(err),
        "error did not move decoder to failed")
    `RLE_ASSERT_NEXT(a_finish_reported,
        in_acc && res_have && n_phase == PH_DONE && !i_cfg_valid,
        r_phase == PH_DONE && o_out_valid && o_finished,
        "finish not reported with done phase")

endmodule
